### src/bia_pkg.sv
// Shared types, request codes and the row search helper for the bitmap id allocator.
// No dependencies.
package bia_pkg;

  localparam int ROW_BITS  = 32;
  localparam int ROW_OFS_W = 5;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_NEXT   = 2'd2;
  localparam logic [1:0] REQ_REMOVE = 2'd3;

  typedef struct packed {
    logic                 hit;
    logic [ROW_OFS_W-1:0] pos;
  } hit_t;

  // lowest set bit of a map row; 0 when none
  function automatic logic [ROW_OFS_W-1:0] lowest_set(input logic [ROW_BITS-1:0] v);
    logic [ROW_OFS_W-1:0] pos;
    pos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = ROW_OFS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

### src/bia_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/bia_rowsrch.sv
// Searches one 32-bit map row for the first free or used bit at or above an offset.
// Depends on bia_pkg.
module bia_rowsrch (
  input  logic [bia_pkg::ROW_BITS-1:0]  row,
  input  logic                          find_set,
  input  logic                          first,
  input  logic [bia_pkg::ROW_OFS_W-1:0] bofs,
  input  logic [bia_pkg::ROW_BITS-1:0]  valid_mask,
  output bia_pkg::hit_t                 res
);

  logic [bia_pkg::ROW_BITS-1:0] ge_mask;
  logic [bia_pkg::ROW_BITS-1:0] cand;

  always_comb begin
    ge_mask = first ? ({bia_pkg::ROW_BITS{1'b1}} << bofs) : {bia_pkg::ROW_BITS{1'b1}};
    cand    = (find_set ? row : ~row) & valid_mask & ge_mask;
    res.hit = |cand;
    res.pos = bia_pkg::lowest_set(cand);
  end

endmodule

### src/bitmap_id_allocator_top.sv
// Bitmap id allocator top level: sequencer over the used-bit map and value store.
// Depends on bia_pkg, bia_ram and bia_rowsrch.
//
// Keeps a used bit and a value for each of ENTRIES ids. Issue a request with start
// while busy is low; exactly one result word comes back on status/result_id/
// result_value, marked by a one-cycle done pulse, and it must be taken in that
// cycle (there is no hold-off). After reset the used map is cleared
// one map row per cycle, with busy high. The map is held 32 ids to a memory row; a
// request reads the row that holds its id on the accept edge and evaluates it the
// next cycle, and find, remove and exact allocate finish in that evaluation. Searching
// allocate and next scan one row per cycle, and next adds a value memory read. The
// value memory is not cleared at reset, so a free id that was never used can hold
// any value, and find masks the value with the used bit.
module bitmap_id_allocator_top #(
  parameter int ENTRIES     = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [9:0]  start_index,
  input  logic [10:0] end_index,
  input  logic [9:0]  target_id,
  input  logic [31:0] entry_value,
  output logic        done,
  output logic        status,
  output logic [9:0]  result_id,
  output logic [31:0] result_value
);

  localparam int ROWS      = (ENTRIES + bia_pkg::ROW_BITS - 1) / bia_pkg::ROW_BITS;
  localparam int ROW_AW    = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int IDX_W     = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int LAST_BITS = ENTRIES - (ROWS - 1) * bia_pkg::ROW_BITS;
  localparam logic [bia_pkg::ROW_BITS-1:0] LAST_MASK =
    bia_pkg::ROW_BITS'((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_VALRD = 2'd3;

  logic [1:0]             state, state_next;
  logic [ROW_AW-1:0]      clr_row;
  logic [ROW_AW-1:0]      cur_row, cur_row_next;
  logic                   first, first_next;

  // latched request
  logic [1:0]             req;
  logic                   search;
  logic                   idx_ok;
  logic [bia_pkg::ROW_OFS_W-1:0] bofs;
  logic [9:0]             start_q;
  logic [9:0]             target_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [9:0]             hit_id;

  // memory ports
  logic                        map_we;
  logic [ROW_AW-1:0]           map_addr;
  logic [bia_pkg::ROW_BITS-1:0] map_wdata, map_rdata;
  logic                        val_we;
  logic [IDX_W-1:0]            val_addr;
  logic [VALUE_WIDTH-1:0]      val_wdata, val_rdata;

  // request decode at the accept edge
  logic        accept;
  logic [9:0]  in_idx;
  logic [31:0] in_ext;

  // evaluation
  logic [bia_pkg::ROW_BITS-1:0] valid_mask;
  logic [bia_pkg::ROW_BITS-1:0] bit_sel;
  logic [bia_pkg::ROW_BITS-1:0] hit_sel;
  bia_pkg::hit_t                srch;
  logic [31:0]                  hit_ext;
  logic                         is_last;
  logic                         cur_bit;
  logic [31:0]                  val_ext;

  logic        out_set;
  logic        out_status;
  logic [9:0]  out_id;
  logic [31:0] out_value;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && (state == ST_IDLE);
  assign in_idx  = (req_type == bia_pkg::REQ_ALLOC) ? start_index : target_id;
  assign in_ext  = 32'(in_idx);

  assign is_last    = (cur_row == LAST_ROW);
  assign valid_mask = is_last ? LAST_MASK : {bia_pkg::ROW_BITS{1'b1}};
  assign bit_sel    = bia_pkg::ROW_BITS'(1) << bofs;
  assign hit_sel    = bia_pkg::ROW_BITS'(1) << srch.pos;
  assign cur_bit    = map_rdata[bofs];
  assign hit_ext    = (32'(cur_row) << bia_pkg::ROW_OFS_W) | 32'(srch.pos);
  assign val_ext    = 32'(64'(val_rdata));

  bia_rowsrch u_rowsrch (
    .row        (map_rdata),
    .find_set   (req == bia_pkg::REQ_NEXT),
    .first      (first),
    .bofs       (bofs),
    .valid_mask (valid_mask),
    .res        (srch)
  );

  bia_ram #(
    .WIDTH (bia_pkg::ROW_BITS),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  bia_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .addr  (val_addr),
    .wdata (val_wdata),
    .rdata (val_rdata)
  );

  // sequencer and memory port steering
  always_comb begin
    state_next   = state;
    cur_row_next = cur_row;
    first_next   = first;
    map_we       = 1'b0;
    map_addr     = cur_row;
    map_wdata    = '0;
    val_we       = 1'b0;
    val_addr     = IDX_W'(target_q);
    val_wdata    = '0;
    out_set      = 1'b0;
    out_status   = 1'b0;
    out_id       = '0;
    out_value    = '0;

    case (state)
      ST_CLEAR: begin
        map_we   = 1'b1;
        map_addr = clr_row;
        if (clr_row == LAST_ROW) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        map_addr = ROW_AW'(in_ext >> bia_pkg::ROW_OFS_W);
        val_addr = IDX_W'(target_id);
        if (accept) begin
          cur_row_next = ROW_AW'(in_ext >> bia_pkg::ROW_OFS_W);
          first_next   = 1'b1;
          state_next   = ST_EVAL;
        end
      end

      ST_EVAL: begin
        case (req)
          bia_pkg::REQ_ALLOC: begin
            if (search) begin
              if (idx_ok && srch.hit) begin
                map_we     = 1'b1;
                map_wdata  = map_rdata | hit_sel;
                val_we     = 1'b1;
                val_addr   = IDX_W'(hit_ext);
                val_wdata  = value_q;
                out_set    = 1'b1;
                out_id     = 10'(hit_ext);
                state_next = ST_IDLE;
              end else if (!idx_ok || is_last) begin
                out_set    = 1'b1;
                out_status = 1'b1;
                state_next = ST_IDLE;
              end else begin
                cur_row_next = cur_row + ROW_AW'(1);
                map_addr     = cur_row + ROW_AW'(1);
                first_next   = 1'b0;
              end
            end else begin
              out_set    = 1'b1;
              state_next = ST_IDLE;
              if (idx_ok && !cur_bit) begin
                map_we    = 1'b1;
                map_wdata = map_rdata | bit_sel;
                val_we    = 1'b1;
                val_addr  = IDX_W'(start_q);
                val_wdata = value_q;
                out_id    = start_q;
              end else begin
                out_status = 1'b1;
              end
            end
          end

          bia_pkg::REQ_FIND: begin
            out_set    = 1'b1;
            out_id     = target_q;
            out_value  = (idx_ok && cur_bit) ? val_ext : 32'd0;
            state_next = ST_IDLE;
          end

          bia_pkg::REQ_NEXT: begin
            if (idx_ok && srch.hit) begin
              val_addr   = IDX_W'(hit_ext);
              state_next = ST_VALRD;
            end else if (!idx_ok || is_last) begin
              out_set    = 1'b1;
              out_status = 1'b1;
              state_next = ST_IDLE;
            end else begin
              cur_row_next = cur_row + ROW_AW'(1);
              map_addr     = cur_row + ROW_AW'(1);
              first_next   = 1'b0;
            end
          end

          default: begin  // remove
            if (idx_ok) begin
              map_we    = 1'b1;
              map_wdata = map_rdata & ~bit_sel;
              val_we    = 1'b1;
            end
            out_set    = 1'b1;
            out_id     = target_q;
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_VALRD: begin
        out_set    = 1'b1;
        out_id     = hit_id;
        out_value  = val_ext;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= out_set;
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + ROW_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_row <= cur_row_next;
    first   <= first_next;
    if (accept) begin
      req      <= req_type;
      search   <= (end_index > (11'(start_index) + 11'd1));
      idx_ok   <= (in_ext < 32'(ENTRIES));
      bofs     <= in_idx[bia_pkg::ROW_OFS_W-1:0];
      start_q  <= start_index;
      target_q <= target_id;
      value_q  <= VALUE_WIDTH'(64'(entry_value));
    end
    if (state == ST_EVAL) begin
      hit_id <= 10'(hit_ext);
    end
    if (out_set) begin
      status       <= out_status;
      result_id    <= out_id;
      result_value <= out_value;
    end
  end

endmodule

### sim/tb_bitmap_id_allocator_top.sv
`timescale 1ns / 1ps
// Testbench for bitmap_id_allocator_top: directed and random request words checked
// against an in-bench model of the used map and the value store.
// Depends on bia_pkg and bitmap_id_allocator_top.
module tb_bitmap_id_allocator_top;

  localparam int NUM_IDS      = 1024;
  localparam int RANDOM_WORDS = 780;
  // limit sized for the worst-case scans and gaps over ~1000 words
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [1:0]  req;
    logic [9:0]  first_id;
    logic [10:0] end_id;
    logic [9:0]  target;
    logic [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  id;
    logic [31:0] value;
  } resp_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        done;
  logic        status;
  logic [9:0]  result_id;
  logic [31:0] result_value;
  req_word_t   drive_word = '0;

  // words waiting to be sent, and responses still owed by the block
  req_word_t  request_words[$];
  resp_word_t expected_responses[$];

  // model copy of the allocator state
  bit          id_used[NUM_IDS];
  logic [31:0] id_value[NUM_IDS];

  int issued_count   = 0;
  int accepted_count = 0;
  int cycle_count    = 0;
  int error_count    = 0;
  int gap_left       = 0;
  int burst_left     = 1;

  bitmap_id_allocator_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (drive_word.req),
    .start_index  (drive_word.first_id),
    .end_index    (drive_word.end_id),
    .target_id    (drive_word.target),
    .entry_value  (drive_word.value),
    .done         (done),
    .status       (status),
    .result_id    (result_id),
    .result_value (result_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset held from the start, released on a falling edge.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Allocator model: updates the used map / value store and returns the response word.
  task automatic compute_response(input req_word_t w, output resp_word_t r);
    int i;
    bit hit;
    r   = '0;
    hit = 1'b0;
    case (w.req)
      bia_pkg::REQ_ALLOC: begin
        // end more than one past start -> search upward, never bounded by end
        if ({1'b0, w.end_id} > {2'b00, w.first_id} + 12'd1) begin
          for (i = int'(w.first_id); i < NUM_IDS && !hit; i++) begin
            if (!id_used[i]) begin
              hit         = 1'b1;
              id_used[i]  = 1'b1;
              id_value[i] = w.value;
              r.id        = i[9:0];
            end
          end
        end else if (!id_used[w.first_id]) begin
          hit                  = 1'b1;
          id_used[w.first_id]  = 1'b1;
          id_value[w.first_id] = w.value;
          r.id                 = w.first_id;
        end
        r.status = !hit;
      end
      bia_pkg::REQ_FIND: begin
        r.id    = w.target;
        r.value = id_value[w.target];
      end
      bia_pkg::REQ_NEXT: begin
        for (i = int'(w.target); i < NUM_IDS && !hit; i++) begin
          if (id_used[i]) begin
            hit     = 1'b1;
            r.id    = i[9:0];
            r.value = id_value[i];
          end
        end
        r.status = !hit;
      end
      default: begin
        id_used[w.target]  = 1'b0;
        id_value[w.target] = '0;
        r.id               = w.target;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [1:0] req, input int first, input int end_val,
                           input int target, input logic [31:0] value);
    req_word_t w;
    w.req      = req;
    w.first_id = first[9:0];
    w.end_id   = end_val[10:0];
    w.target   = target[9:0];
    w.value    = value;
    request_words.push_back(w);
  endtask

  // Allocate with a random end that selects search or exact mode.
  task automatic push_alloc(input int first, input bit search);
    int end_val;
    if (search && first <= NUM_IDS - 2) begin
      end_val = $urandom_range(first + 2, NUM_IDS);
    end else begin
      end_val = $urandom_range(0, first + 1);
    end
    push_word(bia_pkg::REQ_ALLOC, first, end_val, $urandom_range(0, NUM_IDS - 1),
              pick_value());
  endtask

  // Driver: a new word goes out once the current one was taken; bursts with random gaps.
  always @(negedge clk) begin : driver
    if (rst) begin
      start <= 1'b0;
    end else if (!start || accepted_count == issued_count) begin
      if (gap_left > 0 || request_words.size() == 0) begin
        start             <= 1'b0;
        drive_word.target <= 10'($urandom);
        drive_word.value  <= $urandom;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end
      end else begin
        drive_word   <= request_words.pop_front();
        start        <= 1'b1;
        issued_count <= issued_count + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // about a third of bursts run back to back, a few gaps are long
          gap_left   <= ($urandom_range(0, 9) < 3) ? 0 :
                        $urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: checks each done word against the oldest expectation, predicts on accept.
  always @(posedge clk) begin : monitor
    resp_word_t want;
    resp_word_t predicted;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL bitmap_id_allocator_top");
      $finish;
    end else if (!rst) begin
      if (done) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("result word with nothing expected", 32'(result_id), 32'd0);
        end else begin
          want = expected_responses.pop_front();
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (result_id !== want.id)
            report_mismatch("result_id", 32'(result_id), 32'(want.id));
          if (result_value !== want.value)
            report_mismatch("result_value", result_value, want.value);
        end
      end
      if (start && !busy) begin
        compute_response(drive_word, predicted);
        expected_responses.push_back(predicted);
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int n;
    int k;
    int window_base;
    int window_span;
    int pick;
    int id;

    foreach (id_value[i]) id_value[i] = '0;

    // Directed: empty map, both ends of the id range, exact vs search, taken ids,
    // search with no free id, end below start, remove of a free id.
    push_word(bia_pkg::REQ_FIND, 0, 0, 0, 32'h0);
    push_word(bia_pkg::REQ_NEXT, 0, 0, 0, 32'h0);
    push_word(bia_pkg::REQ_ALLOC, 0, 0, 0, 32'hFFFF_FFFF);          // exact, claims 0
    push_word(bia_pkg::REQ_ALLOC, 0, 1, 0, 32'h1234_5678);          // exact, 0 taken
    push_word(bia_pkg::REQ_ALLOC, 0, 2, 0, 32'h0);                  // search, claims 1
    push_word(bia_pkg::REQ_FIND, 0, 0, 0, 32'h0);
    push_word(bia_pkg::REQ_NEXT, 0, 0, 0, 32'h0);
    push_word(bia_pkg::REQ_ALLOC, 1023, 1024, 0, 32'hA5A5_5A5A);    // exact at the top id
    push_word(bia_pkg::REQ_ALLOC, 1022, 1024, 0, 32'h8000_0001);    // search, claims 1022
    push_word(bia_pkg::REQ_ALLOC, 1022, 1024, 0, 32'h7FFF_FFFF);    // search, nothing free
    push_word(bia_pkg::REQ_ALLOC, 1023, 0, 0, 32'h1);               // exact, top id taken
    push_word(bia_pkg::REQ_NEXT, 0, 0, 2, 32'h0);
    push_word(bia_pkg::REQ_NEXT, 0, 0, 1023, 32'h0);
    push_word(bia_pkg::REQ_FIND, 0, 0, 1023, 32'h0);
    push_word(bia_pkg::REQ_REMOVE, 0, 0, 1023, 32'h0);
    push_word(bia_pkg::REQ_FIND, 0, 0, 1023, 32'h0);
    push_word(bia_pkg::REQ_REMOVE, 0, 0, 500, 32'h0);               // free id
    push_word(bia_pkg::REQ_ALLOC, 0, 1024, 0, 32'hDEAD_BEEF);       // search, claims 2
    push_word(bia_pkg::REQ_ALLOC, 700, 3, 0, 32'h0F0F_0F0F);        // end below start
    push_word(bia_pkg::REQ_FIND, 0, 0, 700, 32'h0);
    push_word(bia_pkg::REQ_REMOVE, 0, 0, 0, 32'h0);
    push_word(bia_pkg::REQ_REMOVE, 0, 0, 1, 32'h0);
    push_word(bia_pkg::REQ_REMOVE, 0, 0, 2, 32'h0);
    push_word(bia_pkg::REQ_REMOVE, 0, 0, 700, 32'h0);
    push_word(bia_pkg::REQ_REMOVE, 0, 0, 1022, 32'h0);

    // Random: work inside a moving window so finds, nexts and removes hit live ids.
    window_base = 0;
    window_span = 32;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       window_span = 8;
          1:       window_span = 40;
          default: window_span = 96;
        endcase
        case ($urandom_range(0, 3))
          0:       window_base = 0;
          1:       window_base = NUM_IDS - window_span;
          default: window_base = $urandom_range(0, NUM_IDS - window_span);
        endcase
      end
      // now and then fill the top rows until searches run out, then free most of them
      if (n % 250 == 249) begin
        for (k = 0; k < 40; k++) push_alloc($urandom_range(990, 1010), 1'b1);
        for (k = 990; k < NUM_IDS; k++) begin
          if ($urandom_range(0, 3) != 0)
            push_word(bia_pkg::REQ_REMOVE, 0, 0, k, pick_value());
        end
      end
      id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_IDS - 1) :
           window_base + $urandom_range(0, window_span - 1);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_alloc(id, $urandom_range(0, 2) != 0);
      end else if (pick < 60) begin
        push_word(bia_pkg::REQ_FIND, $urandom_range(0, NUM_IDS - 1),
                  $urandom_range(0, NUM_IDS), id, $urandom);
      end else if (pick < 80) begin
        push_word(bia_pkg::REQ_NEXT, $urandom_range(0, NUM_IDS - 1),
                  $urandom_range(0, NUM_IDS), id, $urandom);
      end else begin
        push_word(bia_pkg::REQ_REMOVE, $urandom_range(0, NUM_IDS - 1),
                  $urandom_range(0, NUM_IDS), id, $urandom);
      end
    end

    @(negedge rst);
    while (request_words.size() != 0 || accepted_count != issued_count ||
           expected_responses.size() != 0) begin
      @(posedge clk);
    end
    // let any stray result word show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS bitmap_id_allocator_top");
    end else begin
      $display("FAIL bitmap_id_allocator_top");
    end
    $finish;
  end

endmodule
